@@ hdl/msws_pkg.sv @@
// ----------------------------------------------------------------------------
// msws_pkg
// Shared types, codes and helpers of the multi-slot watchdog supervisor.
// ----------------------------------------------------------------------------
package msws_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int AVAIL_W   = 5;
  localparam logic [AVAIL_W-1:0] AVAIL_RESET = AVAIL_W'(16);

  localparam logic [31:0] HANDLE_MARK = 32'h8000_0000;
  localparam logic [31:0] UNLOCK_RAW  = 32'h5080_30a4;
  localparam logic [31:0] UNLOCK_CODE = UNLOCK_RAW >> 1;
  localparam logic [7:0]  ID_MASK     = 8'hff;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_ACTIVATE   = 3'd1,
    OP_DEACTIVATE = 3'd2,
    OP_SERVICE    = 3'd3,
    OP_CHECK      = 3'd4
  } op_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_EXPIRED = 2'd1;
  localparam logic [1:0] CAUSE_UNLOCK  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_UPDATE,
    S_SCAN,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;         // capture input transaction
    logic do_register;  // allocate next slot
    logic set_bad;      // invalid handle
    logic do_deact;     // disable slot, check unlock code
    logic rd_life;      // read lifetime of handle slot
    logic wr_deadline;  // write new deadline
    logic scan_start;   // reset scan pointer
    logic scan_step;    // advance scan one slot
    logic finish_check; // decide restart kick
    logic load_out;     // move result into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       handle_ok;
    logic       scan_done;
  } stat_t;

  function automatic logic [31:0] encode_handle(input logic [7:0] id);
    logic [31:0] h;
    h = HANDLE_MARK | ({24'd0, id} << 24) | ({24'd0, ~id & ID_MASK} << 16) | {24'd0, id};
    return h;
  endfunction

endpackage

@@ hdl/multi_slot_watchdog_supervisor_top.sv @@
// ----------------------------------------------------------------------------
// multi_slot_watchdog_supervisor_top
// Multi-slot software watchdog supervisor with handle checking and trip latch.
// ----------------------------------------------------------------------------
// steps: register, deactivate, bad handle and unknown op go through dispatch, then result
// activate and service: dispatch reads the lifetime table, an update step does the 64-bit deadline add
// periodic check: dispatch, then a scan of the registered slots at one slot per cycle
// one transaction in flight; the next is taken once its result is in the output register
// reset (rst, synchronous): slots unregistered and disabled, trip cleared,
//   slots_available back to 16; the slot tables themselves are not cleared
module multi_slot_watchdog_supervisor_top (
  input  logic                         clk,
  input  logic                         rst,
  // operation input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [159:0]                 s_axis_tdata,  // handle, lifetime, unlock_code, now
  input  logic [2:0]                   s_axis_tuser,  // operation
  // result output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status, handle_out, restart_kick, tripped, trip_cause, trip_slot, zero pad
  output logic [47:0]                  m_axis_tdata,
  // slots_available register
  input  logic                         cfg_wr_en,
  input  logic [msws_pkg::AVAIL_W-1:0] cfg_wr_data
);

  // command and status between sequencer and datapath
  msws_pkg::cmd_t  cmd;
  msws_pkg::stat_t stat;

  // sequencer: input/output handshake and operation steps
  msws_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // datapath: slot tables, scan, trip latch and output register
  msws_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_op       (s_axis_tuser),
    .in_data     (s_axis_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (m_axis_tdata)
  );

endmodule

@@ hdl/msws_ctrl.sv @@
// ----------------------------------------------------------------------------
// msws_ctrl
// Sequencer of the supervisor: steps one transaction through the datapath.
// ----------------------------------------------------------------------------
module msws_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  input  msws_pkg::stat_t stat,
  output msws_pkg::cmd_t  cmd
);

  msws_pkg::state_t state, state_next;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msws_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_axis_tready = 1'b0;
    case (state)
      msws_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd.load   = 1'b1;
          state_next = msws_pkg::S_DISPATCH;
        end
      end
      msws_pkg::S_DISPATCH: begin
        state_next = msws_pkg::S_RESULT;
        case (stat.op)
          msws_pkg::OP_REGISTER: cmd.do_register = 1'b1;
          msws_pkg::OP_ACTIVATE, msws_pkg::OP_SERVICE: begin
            if (!stat.handle_ok) begin
              cmd.set_bad = 1'b1;
            end else begin
              cmd.rd_life = 1'b1;
              state_next  = msws_pkg::S_UPDATE;
            end
          end
          msws_pkg::OP_DEACTIVATE: begin
            if (!stat.handle_ok) begin
              cmd.set_bad = 1'b1;
            end else begin
              cmd.do_deact = 1'b1;
            end
          end
          msws_pkg::OP_CHECK: begin
            cmd.scan_start = 1'b1;
            state_next     = msws_pkg::S_SCAN;
          end
          default: ;
        endcase
      end
      msws_pkg::S_UPDATE: begin
        cmd.wr_deadline = 1'b1;
        state_next      = msws_pkg::S_RESULT;
      end
      msws_pkg::S_SCAN: begin
        if (stat.scan_done) begin
          cmd.finish_check = 1'b1;
          state_next       = msws_pkg::S_RESULT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      msws_pkg::S_RESULT: begin
        if (!out_valid || m_axis_tready) begin
          cmd.load_out = 1'b1;
          state_next   = msws_pkg::S_IDLE;
        end
      end
      default: state_next = msws_pkg::S_IDLE;
    endcase
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;

endmodule

@@ hdl/msws_dp.sv @@
// ----------------------------------------------------------------------------
// msws_dp
// Datapath: slot tables, handle check, deadline update, scan and trip latch.
// ----------------------------------------------------------------------------
module msws_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [2:0]                      in_op,
  input  logic [159:0]                    in_data,
  input  logic                            cfg_wr_en,
  input  logic [msws_pkg::AVAIL_W-1:0]    cfg_wr_data,
  input  msws_pkg::cmd_t                  cmd,
  output msws_pkg::stat_t                 stat,
  output logic [47:0]                     out_data
);

  // captured transaction
  logic [2:0]  op_r;
  logic [31:0] handle_r;
  logic [31:0] life_r;
  logic [31:0] code_r;
  logic [63:0] now_r;

  // slot state
  logic [msws_pkg::MAX_SLOTS-1:0] slot_enabled;
  logic [31:0] lifetime_mem [msws_pkg::MAX_SLOTS];
  logic [63:0] deadline_mem [msws_pkg::MAX_SLOTS];
  logic [msws_pkg::CNT_W-1:0]   reg_count;
  logic [msws_pkg::AVAIL_W-1:0] avail;

  logic                        trip_latch;
  logic [1:0]                  trip_reason;
  logic [msws_pkg::SLOT_W-1:0] trip_index;

  // scan pipeline
  logic [msws_pkg::CNT_W-1:0]  scan_idx;
  logic                        rd_pend;
  logic [msws_pkg::SLOT_W-1:0] rd_idx;
  logic [63:0]                 dl_rd;
  logic [31:0]                 life_rd;

  // result
  logic [1:0]  status_r;
  logic [31:0] hout_r;
  logic        kick_r;

  logic [7:0]                  hid;
  logic                        handle_ok;
  logic [msws_pkg::SLOT_W-1:0] sid;
  logic [msws_pkg::SLOT_W-1:0] new_sid;
  logic [msws_pkg::CNT_W-1:0]  limit;
  logic                        scan_more;
  logic                        expired;
  logic                        unlock_bad;

  assign hid       = handle_r[7:0];
  assign handle_ok = (handle_r == msws_pkg::encode_handle(hid))
                  && (32'(hid) < 32'(reg_count));
  assign sid       = msws_pkg::SLOT_W'(hid);
  assign new_sid   = msws_pkg::SLOT_W'(reg_count);
  assign limit     = (32'(avail) > 32'(msws_pkg::MAX_SLOTS))
                   ? msws_pkg::CNT_W'(msws_pkg::MAX_SLOTS) : msws_pkg::CNT_W'(avail);
  assign scan_more = scan_idx < reg_count;
  assign expired   = rd_pend && slot_enabled[rd_idx] && (dl_rd < now_r);
  assign unlock_bad = cmd.do_deact && (code_r != msws_pkg::UNLOCK_CODE);

  assign stat.op        = op_r;
  assign stat.handle_ok = handle_ok;
  assign stat.scan_done = !scan_more && !rd_pend;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      handle_r <= in_data[31:0];
      life_r   <= in_data[63:32];
      code_r   <= in_data[95:64];
      now_r    <= in_data[159:96];
    end
  end

  // slot tables
  always_ff @(posedge clk) begin
    if (cmd.do_register && (reg_count < limit)) begin
      lifetime_mem[new_sid] <= life_r;
    end
    if (cmd.rd_life) begin
      life_rd <= lifetime_mem[sid];
    end
    if (cmd.wr_deadline) begin
      deadline_mem[sid] <= now_r + {32'd0, life_rd};
    end
    if (cmd.scan_step && scan_more) begin
      dl_rd  <= deadline_mem[msws_pkg::SLOT_W'(scan_idx)];
      rd_idx <= msws_pkg::SLOT_W'(scan_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_enabled <= '0;
      reg_count    <= '0;
      avail        <= msws_pkg::AVAIL_RESET;
      trip_latch   <= 1'b0;
      trip_reason  <= msws_pkg::CAUSE_NONE;
      trip_index   <= '0;
      scan_idx     <= '0;
      rd_pend      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        avail <= cfg_wr_data;
      end
      if (cmd.do_register && (reg_count < limit)) begin
        slot_enabled[new_sid] <= 1'b0;
        reg_count             <= reg_count + 1'b1;
      end
      if (cmd.do_deact) begin
        slot_enabled[sid] <= 1'b0;
      end
      if (cmd.wr_deadline && (op_r == msws_pkg::OP_ACTIVATE)) begin
        slot_enabled[sid] <= 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
        rd_pend  <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_pend <= scan_more;
        if (scan_more) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      // first trip wins; scan runs in slot order so the lowest slot lands first
      if (!trip_latch && unlock_bad) begin
        trip_latch  <= 1'b1;
        trip_reason <= msws_pkg::CAUSE_UNLOCK;
        trip_index  <= sid;
      end else if (!trip_latch && cmd.scan_step && expired) begin
        trip_latch  <= 1'b1;
        trip_reason <= msws_pkg::CAUSE_EXPIRED;
        trip_index  <= rd_idx;
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= msws_pkg::STAT_OK;
      hout_r   <= '0;
      kick_r   <= 1'b0;
    end else begin
      if (cmd.do_register) begin
        if (reg_count < limit) begin
          hout_r <= msws_pkg::encode_handle(8'(reg_count));
        end else begin
          status_r <= msws_pkg::STAT_FULL;
        end
      end
      if (cmd.set_bad) begin
        status_r <= msws_pkg::STAT_BAD;
      end
      if (cmd.finish_check) begin
        kick_r <= !trip_latch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {6'd0, 4'(trip_index), trip_reason, trip_latch, kick_r, hout_r, status_r};
    end
  end

endmodule

@@ hdl/msws_chk.sv @@
// ----------------------------------------------------------------------------
// msws_chk
// Port-level checks of the supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module msws_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic seen_trip;
  logic out_hs;

  assign out_hs = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_trip <= 1'b0;
    end else if (out_hs && m_axis_tdata[35]) begin
      seen_trip <= 1'b1;
    end
  end

  // trip latch is sticky until reset
  a_trip_sticky: assert property (@(posedge clk) disable iff (rst)
    out_hs && seen_trip |-> m_axis_tdata[35])
    else $error("trip flag dropped without reset");

  // no restart kick while tripped
  a_kick_clear: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[34] |-> !m_axis_tdata[35])
    else $error("kick given while tripped");

  // a tripped result carries a cause
  a_trip_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[35] |-> m_axis_tdata[37:36] != msws_pkg::CAUSE_NONE)
    else $error("trip without cause");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind multi_slot_watchdog_supervisor_top msws_chk u_msws_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ test/multi_slot_watchdog_supervisor_top_test.sv @@
// ----------------------------------------------------------------------------
// multi_slot_watchdog_supervisor_top_test
// Self-checking bench for the multi-slot watchdog supervisor: a queue-fed
// driver offers operations, a transaction-level predictor works out each result as
// its transaction is accepted, and a monitor compares every field of every
// result. The slot count is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module multi_slot_watchdog_supervisor_top_test;
  import msws_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int SHOWN_MAX    = 10;
  localparam int CHOKE_CYCLES = 400;

  // operation codes the block does not define, sent as noise
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] handle;
    logic [31:0] life;
    logic [31:0] code;
    logic [63:0] now;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic        kick;
    logic        tripped;
    logic [1:0]  cause;
    logic [3:0]  slot;
  } verdict_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [159:0]       s_axis_tdata  = '0;
  logic [2:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [47:0]        m_axis_tdata;
  logic               cfg_wr_en     = 1'b0;
  logic [AVAIL_W-1:0] cfg_wr_data   = '0;

  // operations waiting to be offered, and results owed by the block
  request_t pend_q[$];
  verdict_t verdict_q[$];

  // predictor state
  logic               sh_enabled  [MAX_SLOTS];
  logic [31:0]        sh_life     [MAX_SLOTS];
  logic [63:0]        sh_deadline [MAX_SLOTS];
  int unsigned        sh_registered;
  logic               sh_trip;
  logic [1:0]         sh_cause;
  logic [3:0]         sh_slot;
  logic [AVAIL_W-1:0] sh_avail;

  // stimulus-side bookkeeping
  int unsigned gen_regs;
  int unsigned gen_cap;
  logic [63:0] tick;

  // traffic shaping shared with driver and receiver
  logic calm         = 1'b0;
  logic choke_req    = 1'b0;
  logic choke_started = 1'b0;
  int   choke_left   = 0;

  int errors    = 0;
  int cycles    = 0;
  int n_sent    = 0;
  int n_results = 0;
  int n_kicks   = 0;
  int n_enrol   = 0;
  int n_full    = 0;
  int n_bad     = 0;

  multi_slot_watchdog_supervisor_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // self-checking handle: mark bit, id, inverted id, zero byte, id
  function automatic logic [31:0] slot_tag(int unsigned id);
    logic [7:0] b;
    b = 8'(id);
    return {b | 8'h80, ~b, 8'h00, b};
  endfunction

  // only the first trip is recorded
  function automatic void raise_trip(logic [1:0] why, logic [3:0] idx);
    if (!sh_trip) begin
      sh_trip  = 1'b1;
      sh_cause = why;
      sh_slot  = idx;
    end
  endfunction

  function automatic verdict_t supervise(request_t rq);
    verdict_t    v;
    int unsigned cap;
    int unsigned i;
    logic [7:0]  low;
    logic        valid;
    v     = '0;
    cap   = (sh_avail > MAX_SLOTS) ? MAX_SLOTS : sh_avail;
    low   = rq.handle[7:0];
    // a handle must be exactly encoded and name a slot already handed out
    valid = (rq.handle == slot_tag(low)) && (low < sh_registered);
    case (rq.op)
      OP_REGISTER: begin
        if (sh_registered >= cap) begin
          v.status = STAT_FULL;
          n_full++;
        end else begin
          sh_enabled[sh_registered] = 1'b0;
          sh_life[sh_registered]    = rq.life;
          v.handle_out              = slot_tag(sh_registered);
          sh_registered++;
          n_enrol++;
        end
      end
      OP_ACTIVATE, OP_DEACTIVATE, OP_SERVICE: begin
        if (!valid) begin
          v.status = STAT_BAD;
          n_bad++;
        end else if (rq.op == OP_DEACTIVATE) begin
          if (rq.code != UNLOCK_CODE) raise_trip(CAUSE_UNLOCK, low[3:0]);
          sh_enabled[low] = 1'b0;
        end else begin
          // service of a disabled slot moves the deadline but leaves it off
          if (rq.op == OP_ACTIVATE) sh_enabled[low] = 1'b1;
          sh_deadline[low] = rq.now + {32'd0, sh_life[low]};
        end
      end
      OP_CHECK: begin
        // strict compare, lowest expired slot wins
        for (i = 0; i < sh_registered; i++) begin
          if (sh_enabled[i] && sh_deadline[i] < rq.now) raise_trip(CAUSE_EXPIRED, 4'(i));
        end
        v.kick = !sh_trip;
        if (v.kick) n_kicks++;
      end
      default: begin
        // spare codes: status ok, no kick, nothing changes
      end
    endcase
    v.tripped = sh_trip;
    v.cause   = sh_cause;
    v.slot    = sh_slot;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers the head of the pending queue, holds it until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      // transaction accepted at this edge: predict its result now
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_q.push_back(supervise(pend_q[0]));
        pend_q.pop_front();
        n_sent++;
      end
      // an offer that is still waiting must stay put
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pend_q[0].now, pend_q[0].code, pend_q[0].life, pend_q[0].handle};
          s_axis_tuser  <= pend_q[0].op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (choke_left > 0) begin
      m_axis_tready <= 1'b0;
      choke_left    <= choke_left - 1;
    end else if (choke_req && !choke_started) begin
      // sender keeps offering, so the block fills and stalls its input
      choke_started <= 1'b1;
      choke_left    <= CHOKE_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result against the oldest owed one
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(string what, verdict_t want, verdict_t got);
    errors++;
    if (errors <= SHOWN_MAX)
      $display({"[%0d] mismatch in%s: want st=%0d h=%h k=%0d t=%0d c=%0d s=%0d,",
                " got st=%0d h=%h k=%0d t=%0d c=%0d s=%0d"},
               n_results, what, want.status, want.handle_out, want.kick, want.tripped,
               want.cause, want.slot, got.status, got.handle_out, got.kick, got.tripped,
               got.cause, got.slot);
  endfunction

  always @(posedge clk) begin : watch_results
    verdict_t got;
    verdict_t want;
    string    bad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status     = m_axis_tdata[1:0];
      got.handle_out = m_axis_tdata[33:2];
      got.kick       = m_axis_tdata[34];
      got.tripped    = m_axis_tdata[35];
      got.cause      = m_axis_tdata[37:36];
      got.slot       = m_axis_tdata[41:38];
      n_results++;
      if (verdict_q.size() == 0) begin
        note_mismatch(" (no result owed)", '0, got);
      end else begin
        want = verdict_q.pop_front();
        bad  = "";
        if (got.status !== want.status)         bad = {bad, " status"};
        if (got.handle_out !== want.handle_out) bad = {bad, " handle_out"};
        if (got.kick !== want.kick)             bad = {bad, " restart_kick"};
        if (got.tripped !== want.tripped)       bad = {bad, " tripped"};
        if (got.cause !== want.cause)           bad = {bad, " trip_cause"};
        if (got.slot !== want.slot)             bad = {bad, " trip_slot"};
        if (bad != "") note_mismatch(bad, want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push(logic [2:0] op, logic [31:0] handle, logic [31:0] life,
                      logic [31:0] code, logic [63:0] now);
    request_t rq;
    rq.op     = op;
    rq.handle = handle;
    rq.life   = life;
    rq.code   = code;
    rq.now    = now;
    pend_q.push_back(rq);
  endtask

  // block idle: nothing queued, nothing offered, nothing owed
  task automatic drain();
    while (pend_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_slots(logic [AVAIL_W-1:0] v);
    drain();
    repeat (6) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sh_avail = v;
    gen_cap  = (v > MAX_SLOTS) ? MAX_SLOTS : v;
  endtask

  task automatic enrol(logic [31:0] life);
    push(OP_REGISTER, $urandom, life, $urandom, tick);
    if (gen_regs < gen_cap) gen_regs++;
  endtask

  // operations that change nothing: broken handles and spare codes
  task automatic push_noise();
    logic [31:0] h;
    int          pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: h = $urandom;
      // one bit flipped in a live handle
      1: h = slot_tag((gen_regs > 0) ? $urandom_range(0, gen_regs - 1) : 0)
             ^ (32'd1 << $urandom_range(0, 31));
      // well-formed handle of a slot not handed out
      default: h = slot_tag($urandom_range(gen_regs, 255));
    endcase
    if (pick == 3)
      push(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), $urandom, $urandom, $urandom,
           {$urandom, $urandom});
    else
      push(3'($urandom_range(OP_ACTIVATE, OP_SERVICE)), h, $urandom, $urandom,
           {$urandom, $urandom});
  endtask

  // well-formed traffic on live slots; wild_pct adds items that may trip
  task automatic run_traffic(int count, int wild_pct);
    int k;
    int roll;
    int unsigned s;
    for (k = 0; k < count; k++) begin
      tick += 64'($urandom_range(0, 2000));
      roll = $urandom_range(0, 99);
      s    = (gen_regs > 0) ? $urandom_range(0, gen_regs - 1) : 0;
      if (gen_regs > 0 && $urandom_range(0, 99) < wild_pct) begin
        case (roll % 3)
          0: push(OP_CHECK, $urandom, $urandom, $urandom, {$urandom, $urandom});
          1: push(OP_DEACTIVATE, slot_tag(s), $urandom, $urandom, tick);
          default: push(OP_ACTIVATE, slot_tag(s), $urandom, $urandom, {$urandom, $urandom});
        endcase
      end else if (roll >= 90) begin
        push_noise();
      end else if (roll >= 83) begin
        // long lifetimes keep healthy slots clear of their deadlines
        enrol($urandom | HANDLE_MARK);
      end else if (gen_regs == 0 || roll >= 58) begin
        push(OP_CHECK, $urandom, $urandom, $urandom, tick);
      end else if (roll >= 40 && s != 0) begin
        // slot 0 has a zero lifetime, so it is never activated here
        push(OP_ACTIVATE, slot_tag(s), $urandom, $urandom, tick);
      end else if (roll >= 32) begin
        push(OP_DEACTIVATE, slot_tag(s), $urandom, UNLOCK_CODE, tick);
      end else begin
        push(OP_SERVICE, slot_tag(s), $urandom, $urandom, tick);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int          i;
    int          scenario;
    logic [63:0] t0;
    for (i = 0; i < MAX_SLOTS; i++) sh_enabled[i] = 1'b0;
    sh_registered = 0;
    sh_trip       = 1'b0;
    sh_cause      = CAUSE_NONE;
    sh_slot       = '0;
    sh_avail      = AVAIL_RESET;
    gen_regs      = 0;
    gen_cap       = MAX_SLOTS;
    // tick base well away from both ends of the 64-bit range
    tick = {32'($urandom_range(2, 32'hFFFF_FFF0)), $urandom};
    t0   = tick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no slots on offer at all
    set_slots('0);
    enrol($urandom);
    push(OP_CHECK, $urandom, $urandom, $urandom, t0);
    push(OP_ACTIVATE, slot_tag(0), $urandom, $urandom, t0);
    push(OP_DEACTIVATE, slot_tag(0), $urandom, '0, t0);
    push(OP_SERVICE, '1, '1, '1, '1);
    push(OP_SPARE_LO, $urandom, $urandom, $urandom, {$urandom, $urandom});
    push(OP_SPARE_HI, '1, '1, '1, '1);
    push(OP_CHECK, '0, '0, '0, '0);

    // two slots: zero and full-scale lifetimes, then a refused third
    set_slots(AVAIL_W'(2));
    enrol('0);
    enrol('1);
    enrol($urandom);
    push(OP_ACTIVATE, slot_tag(0), $urandom, $urandom, t0);
    push(OP_CHECK, $urandom, $urandom, $urandom, t0);          // deadline equal to now
    push(OP_SERVICE, slot_tag(0), $urandom, $urandom, t0 + 1);
    push(OP_DEACTIVATE, slot_tag(0), $urandom, UNLOCK_CODE, t0 + 1);
    push(OP_ACTIVATE, slot_tag(1), $urandom, $urandom, '1);    // deadline wraps round
    push(OP_CHECK, $urandom, $urandom, $urandom, '0);
    push(OP_SERVICE, slot_tag(1) ^ 32'h0000_0200, $urandom, $urandom, t0);
    push(OP_ACTIVATE, slot_tag(2), $urandom, $urandom, t0);    // not handed out yet
    push(OP_SERVICE, slot_tag(1), $urandom, $urandom, t0);
    push(OP_CHECK, $urandom, $urandom, $urandom, t0 + 2);
    push(OP_SERVICE, slot_tag(0), $urandom, $urandom, t0 + 3); // stays disabled
    push(OP_CHECK, $urandom, $urandom, $urandom, t0 + 3);
    tick = t0 + 10;

    // steady stretch with no idling on either side
    set_slots(AVAIL_W'(5));
    calm = 1'b1;
    run_traffic(230, 0);
    drain();
    calm = 1'b0;

    // count shrunk below what is registered, with a long receiver hold-off
    set_slots(AVAIL_W'(1));
    choke_req = 1'b1;
    run_traffic(230, 0);

    set_slots('1);
    run_traffic(230, 0);

    set_slots(AVAIL_W'(MAX_SLOTS));
    run_traffic(230, 0);

    set_slots(AVAIL_W'($urandom_range(1, 31)));
    run_traffic(220, 0);

    // one way into the trip, then traffic that keeps poking the latch
    scenario = $urandom_range(0, 3);
    tick += 64'd5;
    case (scenario)
      0: push(OP_DEACTIVATE, slot_tag($urandom_range(0, gen_regs - 1)), $urandom,
              UNLOCK_CODE ^ (32'd1 << $urandom_range(0, 31)), tick);
      1: begin
        push(OP_ACTIVATE, slot_tag(0), $urandom, $urandom, tick);
        push(OP_CHECK, $urandom, $urandom, $urandom, tick);
        push(OP_CHECK, $urandom, $urandom, $urandom, tick + 1);
      end
      2: push(OP_CHECK, $urandom, $urandom, $urandom, '1);
      default: begin
        push(OP_ACTIVATE, slot_tag(1), $urandom, $urandom, '1);
        push(OP_CHECK, $urandom, $urandom, $urandom, tick);
      end
    endcase
    run_traffic(170, 30);

    drain();
    repeat (40) @(posedge clk);
    if (verdict_q.size() != 0) begin
      errors++;
      $display("%0d results never arrived", verdict_q.size());
    end
    $display("covered %0d transactions: %0d slots enrolled, %0d refused,",
             n_sent, n_enrol, n_full);
    $display("  %0d bad handles, %0d kicks", n_bad, n_kicks);
    $display("trip scenario %0d: latched=%0d cause=%0d slot=%0d, %0d mismatches",
             scenario, sh_trip, sh_cause, sh_slot, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog on the bench itself
  initial begin
    wait (cycles >= LIMIT_CYCLES);
    $display("timeout after %0d cycles", cycles);
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/msws_pkg.sv
hdl/msws_ctrl.sv
hdl/msws_dp.sv
hdl/multi_slot_watchdog_supervisor_top.sv
hdl/msws_chk.sv
test/multi_slot_watchdog_supervisor_top_test.sv
